// ===== rtl/sdx_pkg.sv =====
`default_nettype none

package sdx_pkg;

    localparam int unsigned CODE_LEN = 4;
    localparam int unsigned CNT_W    = $clog2(CODE_LEN + 1);
    localparam int unsigned IDX_W    = $clog2(CODE_LEN);
    localparam logic [7:0]  PAD_CHAR = 8'h30;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    typedef logic [CODE_LEN-1:0][7:0] code_t;

    // Letters that never enter the code after the first position
    function automatic logic is_dropped(input logic [7:0] c);
        logic drop;
        begin
            drop = (c == "a") || (c == "e") || (c == "h") || (c == "i") ||
                   (c == "o") || (c == "u") || (c == "w") || (c == "y");
            return drop;
        end
    endfunction

    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] m;
        begin
            unique case (c)
                "b", "f", "p", "v":                     m = "1";
                "c", "g", "j", "k", "q", "s", "x", "z": m = "2";
                "d", "t":                               m = "3";
                "l":                                    m = "4";
                "m", "n":                               m = "5";
                "r":                                    m = "6";
                default:                                m = c;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdx_input_stage.sv =====
`default_nettype none

module sdx_input_stage
    import sdx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_in,
    input  wire logic       word_end,
    input  wire logic       advance,
    output logic            held_valid,
    output char_word_t      held_word
);

    logic       valid_reg;
    logic       valid_next;
    char_word_t word_reg;
    logic       take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load on accept only
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg.ch   <= char_in;
            word_reg.last <= word_end;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdx_code_core.sv =====
`default_nettype none

module sdx_code_core
    import sdx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       held_valid,
    input  wire char_word_t held_word,
    input  wire logic       out_free,
    output logic            advance,
    output logic            result_load,
    output code_t           result_code
);

    logic             in_word_reg;
    logic             in_word_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       prev_reg;
    logic [7:0]       prev_next;
    code_t            buf_reg;
    code_t            buf_next;
    code_t            buf_kept;
    logic [7:0]       mapped;
    logic [7:0]       kept_char;
    logic             keep;

    // A word end needs room in the result register; other characters never wait
    assign advance     = held_valid && (!held_word.last || out_free);
    assign result_load = advance && held_word.last;
    assign result_code = buf_kept;

    always_comb
    begin
        mapped    = map_char(held_word.ch);
        kept_char = in_word_reg ? mapped : held_word.ch;
        keep      = !in_word_reg ||
                    (!is_dropped(held_word.ch) && (mapped != prev_reg));

        buf_kept     = buf_reg;
        count_next   = count_reg;
        prev_next    = prev_reg;
        in_word_next = 1'b1;
        if (keep)
        begin
            prev_next = kept_char;
            if (count_reg < CNT_W'(CODE_LEN))
            begin
                buf_kept[count_reg[IDX_W-1:0]] = kept_char;
                count_next = count_reg + CNT_W'(1);
            end
        end
        buf_next = buf_kept;

        // Drop all word state once the code is handed off
        if (held_word.last)
        begin
            in_word_next = 1'b0;
            count_next   = '0;
            prev_next    = '0;
            buf_next     = {CODE_LEN{PAD_CHAR}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            count_reg   <= '0;
            prev_reg    <= '0;
            buf_reg     <= {CODE_LEN{PAD_CHAR}};
        end
        else if (advance)
        begin
            in_word_reg <= in_word_next;
            count_reg   <= count_next;
            prev_reg    <= prev_next;
            buf_reg     <= buf_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdx_output_stage.sv =====
`default_nettype none

module sdx_output_stage
    import sdx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       result_load,
    input  wire code_t      result_code,
    output logic            out_free,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      code_first,
    output logic [7:0]      code_second,
    output logic [7:0]      code_third,
    output logic [7:0]      code_fourth
);

    logic  valid_reg;
    logic  valid_next;
    code_t code_reg;

    assign out_free    = !valid_reg || !out_stall;
    assign out_valid   = valid_reg;
    assign code_first  = code_reg[0];
    assign code_second = code_reg[1];
    assign code_third  = code_reg[2];
    assign code_fourth = code_reg[3];

    always_comb
    begin
        if (result_load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            code_reg <= result_code;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/soundex_encoder_top.sv =====
// Soundex-style phonetic encoder, one character per input transfer.
// Input channel: in_valid / in_stall carry char_in and word_end; word_end
//   marks the last character of a word. A character is taken at a rising edge
//   with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry code_first..code_fourth, one
//   word per input word, given after its last character.
// Path: a character accepted into the input register is folded into the
//   code state when the core advances it; the code of a last character is
//   loaded into the result register in that same step and then shown.
// Throughput: one character per cycle while no word end is held back, set
//   by the single register-to-register pass through the character map and
//   the compare with the previous kept character.
// Stall: characters that do not end a word never wait. A word end waits in
//   the input register while the result register is full and stalled; the
//   input then stalls until the result is taken.
// Reset (rst_n low, asynchronous): both channels go empty and the code
//   state returns to the start of a word with the code buffer all '0'.
`default_nettype none

module soundex_encoder_top
    import sdx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_in,
    input  wire logic       word_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      code_first,
    output logic [7:0]      code_second,
    output logic [7:0]      code_third,
    output logic [7:0]      code_fourth
);

    logic       held_valid;
    char_word_t held_word;
    logic       advance;
    logic       out_free;
    logic       result_load;
    code_t      result_code;

    // Hold the incoming character until the core consumes it
    sdx_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .word_end   (word_end),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    // Map, merge duplicates and build the code; advance state per character
    sdx_code_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .held_valid  (held_valid),
        .held_word   (held_word),
        .out_free    (out_free),
        .advance     (advance),
        .result_load (result_load),
        .result_code (result_code)
    );

    // Register the finished code until the receiver takes it
    sdx_output_stage u_output
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_load (result_load),
        .result_code (result_code),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_first  (code_first),
        .code_second (code_second),
        .code_third  (code_third),
        .code_fourth (code_fourth)
    );

endmodule

`default_nettype wire
